>>> rtl/skrt_pkg.sv
// shared types and codes for the sorted key record table
`timescale 1ns / 1ps

package skrt_pkg;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_PRESENT = 2'd1;
	localparam logic [1:0] STAT_ABSENT  = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] key;
		logic [9:0]  score_one;
		logic [9:0]  score_two;
		logic [9:0]  score_three;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] position;
		logic [6:0] entry_count;
		logic [9:0] found_one;
		logic [9:0] found_two;
		logic [9:0] found_three;
	} rsp_t;

	// one stored record: key and its three scores
	typedef struct packed {
		logic [31:0] key;
		logic [9:0]  score_three;
		logic [9:0]  score_two;
		logic [9:0]  score_one;
	} rec_t;

endpackage

>>> rtl/skrt_if.sv
// request and response channel interfaces with valid/ready handshake
`timescale 1ns / 1ps

interface skrt_req_if import skrt_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface skrt_rsp_if import skrt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sorted_key_record_table_core.sv
// sorted key record table: top level with record memory and output register
// throughput: one request at a time, set by the single read port walking the table
// reset: asynchronous, empties the table; memory contents are not cleared
`timescale 1ns / 1ps

module sorted_key_record_table_core import skrt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	skrt_req_if.sink    req,
	skrt_rsp_if.source  rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic          res_valid;
	logic          res_ready;
	rsp_t          res_data;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	rec_t          mem_wdata;
	logic [AW-1:0] mem_raddr;
	rec_t          mem_rdata;
	logic          out_vld_q;
	rsp_t          out_q;

	skrt_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req.data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	skrt_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register between the sequencer and the response channel
	assign res_ready = !out_vld_q || rsp.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_data;
		end
	end

endmodule

>>> rtl/skrt_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module skrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/skrt_ctrl.sv
// search and shift sequencer working on the record memory
`timescale 1ns / 1ps

module skrt_ctrl import skrt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  req_t                        req_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output rsp_t                        res_data,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output rec_t                        mem_wdata,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  rec_t                        mem_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_PLACE  = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]    state_q;
	req_t          req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] chk_ptr_q;
	logic          chk_vld_q;
	logic          more_q;
	logic [CW-1:0] pos_q;
	rsp_t          res_q;

	logic          stop_hit;
	logic          key_eq;
	logic          search_end;
	logic [CW-1:0] pos_end;
	logic          shift_down;
	logic [CW-1:0] end_ptr;
	rec_t          new_rec;

	// search compare on the entry read in the previous cycle
	assign stop_hit   = chk_vld_q && (mem_rdata.key >= req_q.key);
	assign key_eq     = stop_hit && (mem_rdata.key == req_q.key);
	assign search_end = stop_hit || (rd_ptr_q >= count_q);
	assign pos_end    = stop_hit ? chk_ptr_q : count_q;

	// delete moves entries towards lower addresses, insert towards higher
	assign shift_down = (req_q.opcode == OP_DELETE);
	assign end_ptr    = shift_down ? CW'(count_q - 1'b1) : pos_q;

	assign new_rec.key         = req_q.key;
	assign new_rec.score_one   = req_q.score_one;
	assign new_rec.score_two   = req_q.score_two;
	assign new_rec.score_three = req_q.score_three;

	// memory port control
	always_comb begin
		mem_raddr = rd_ptr_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wdata = new_rec;
		if (state_q == S_SHIFT) begin
			mem_we    = chk_vld_q;
			mem_wdata = mem_rdata;
			if (shift_down) begin
				mem_waddr = AW'(chk_ptr_q - 1'b1);
			end else begin
				mem_waddr = AW'(chk_ptr_q + 1'b1);
			end
		end else if (state_q == S_PLACE) begin
			mem_we = 1'b1;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res_data             = res_q;
		res_data.entry_count = 7'(count_q);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			chk_vld_q <= 1'b0;
			more_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q     <= req_data;
						res_q     <= '0;
						rd_ptr_q  <= '0;
						chk_vld_q <= 1'b0;
						if (req_data.opcode inside {OP_INSERT, OP_DELETE, OP_LOOKUP}) begin
							state_q <= S_SEARCH;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SEARCH: begin
					if (search_end) begin
						chk_vld_q <= 1'b0;
						pos_q     <= pos_end;
						state_q   <= S_DONE;
						case (req_q.opcode)
							OP_INSERT: begin
								if (key_eq) begin
									res_q.status <= STAT_PRESENT;
								end else if (count_q == FULL_COUNT) begin
									res_q.status <= STAT_FULL;
								end else if (pos_end == count_q) begin
									state_q <= S_PLACE;
								end else begin
									rd_ptr_q <= CW'(count_q - 1'b1);
									more_q   <= 1'b1;
									state_q  <= S_SHIFT;
								end
							end
							OP_DELETE: begin
								if (!key_eq) begin
									res_q.status <= STAT_ABSENT;
								end else begin
									res_q.position <= 6'(pos_end);
									if (CW'(pos_end + 1'b1) == count_q) begin
										count_q <= CW'(count_q - 1'b1);
									end else begin
										rd_ptr_q <= CW'(pos_end + 1'b1);
										more_q   <= 1'b1;
										state_q  <= S_SHIFT;
									end
								end
							end
							default: begin
								if (!key_eq) begin
									res_q.status <= STAT_ABSENT;
								end else begin
									res_q.position    <= 6'(pos_end);
									res_q.found_one   <= mem_rdata.score_one;
									res_q.found_two   <= mem_rdata.score_two;
									res_q.found_three <= mem_rdata.score_three;
								end
							end
						endcase
					end else begin
						// keep one read in flight ahead of the compare
						chk_vld_q <= 1'b1;
						chk_ptr_q <= rd_ptr_q;
						rd_ptr_q  <= CW'(rd_ptr_q + 1'b1);
					end
				end
				S_SHIFT: begin
					if (more_q) begin
						chk_vld_q <= 1'b1;
						chk_ptr_q <= rd_ptr_q;
						if (rd_ptr_q == end_ptr) begin
							more_q <= 1'b0;
						end else if (shift_down) begin
							rd_ptr_q <= CW'(rd_ptr_q + 1'b1);
						end else begin
							rd_ptr_q <= CW'(rd_ptr_q - 1'b1);
						end
					end else begin
						// last move written this cycle
						chk_vld_q <= 1'b0;
						if (shift_down) begin
							count_q <= CW'(count_q - 1'b1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_PLACE;
						end
					end
				end
				S_PLACE: begin
					res_q.position <= 6'(pos_q);
					count_q        <= CW'(count_q + 1'b1);
					state_q        <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
